### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on clk, off while rst_n is low.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/d31_pkg.sv
package d31_pkg;

  localparam int unsigned MaxDigits = 255;
  localparam int unsigned Radix     = 31;
  // floor(2^24 / 31): quotient estimate is at most one low
  localparam int unsigned Recip     = 541200;
  localparam int unsigned RecipShift = 24;

  localparam logic [1:0] DigitCountAddr = 2'd0;

  typedef enum logic [2:0] {
    StFetch = 3'd0,
    StLoad  = 3'd1,
    StMul   = 3'd2,
    StRem   = 3'd3,
    StQuo   = 3'd4,
    StNibLo = 3'd5,
    StNibHi = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    UopNop,
    UopLoad,
    UopMul,
    UopEmitRem,
    UopEmitQuo,
    UopEmitLo,
    UopEmitHi
  } uop_e;

  typedef enum logic [2:0] {
    CondNone,
    CondWaitIn,
    CondDispatch,
    CondLoop,
    CondLastDigit
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    uop_e  op;
    cond_e cond;
    step_e next;
    step_e alt;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_e pc);
    ucode_t w;
    w = '{in_ready: 1'b0, op: UopNop, cond: CondNone, next: StFetch, alt: StFetch};
    case (pc)
      StFetch: w = '{1'b1, UopNop,     CondWaitIn,    StLoad,  StFetch};
      StLoad:  w = '{1'b0, UopLoad,    CondDispatch,  StFetch, StFetch};
      StMul:   w = '{1'b0, UopMul,     CondNone,      StRem,   StRem};
      StRem:   w = '{1'b0, UopEmitRem, CondLoop,      StQuo,   StMul};
      StQuo:   w = '{1'b0, UopEmitQuo, CondNone,      StFetch, StFetch};
      StNibLo: w = '{1'b0, UopEmitLo,  CondLastDigit, StNibHi, StFetch};
      StNibHi: w = '{1'b0, UopEmitHi,  CondNone,      StFetch, StFetch};
      default: w = '{1'b0, UopNop,     CondNone,      StFetch, StFetch};
    endcase
    return w;
  endfunction

endpackage

### design/d31_in_if.sv
interface d31_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       start_req;

  modport source (output valid, output digest_byte, output start_req, input ready);
  modport sink (input valid, input digest_byte, input start_req, output ready);
endinterface

### design/d31_out_if.sv
interface d31_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] digit;
  logic       last_of_item;
  logic       last_of_vector;

  modport source (output valid, output digit, output last_of_item, output last_of_vector,
                  input ready);
  modport sink (input valid, input digit, input last_of_item, input last_of_vector,
                output ready);
endinterface

### design/d31_div.sv
module d31_div
  import d31_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] w_i,
  output logic [19:0] q_o,
  output logic [4:0]  r_o
);

  logic [43:0] prod;
  logic [19:0] q_est_q;
  logic [25:0] rem_full;
  logic [5:0]  r_est;

  assign prod = 44'(w_i) * 44'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_est_q <= prod[RecipShift +: 20];
    end
  end

  // w - 31*q = w - 32*q + q
  assign rem_full = {2'b0, w_i} - {1'b0, q_est_q, 5'b0} + {6'b0, q_est_q};
  assign r_est    = rem_full[5:0];

  always_comb begin
    if (r_est >= 6'(Radix)) begin
      q_o = q_est_q + 20'd1;
      r_o = 5'(r_est - 6'(Radix));
    end else begin
      q_o = q_est_q;
      r_o = r_est[4:0];
    end
  end

endmodule

### design/digest_to_base31_digits.sv
// channel | dir | handshake   | payload
// in_i    | in  | valid/ready | digest_byte[7:0], start_req
// out_o   | out | valid/ready | digit[4:0], last_of_item, last_of_vector
// cfg     | in  | APB write   | digit_count[7:0] at byte address 0
//
// A byte that gives no digit, or only collects into a group, passes the fetch and load steps.
// Nibble bytes add one or two emit steps; the third byte of a group runs four multiply and
// remainder step pairs through the shared reciprocal divide unit, then one quotient step.
// Output stall holds the sequencer at its emit step; one digit waits in the
// output register. Reset is asynchronous and clears all counts and the sequencer.
`include "assert_macros.svh"

module digest_to_base31_digits
  import d31_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  d31_in_if.sink      in_i,
  d31_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  step_e       pc_q, pc_d;
  ucode_t      uw;
  logic [7:0]  count_q;
  logic [7:0]  dl_q, dl_d;
  logic [15:0] store_q, store_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  byte_q;
  logic        start_q;
  logic [23:0] w_q, w_d;
  logic        ov_q, ov_d;
  logic [4:0]  digit_q, digit_d;
  logic        lit_q, lit_d;
  logic        lvec_q, lvec_d;
  logic        accept, out_free, emit, stall;
  logic [7:0]  dl_clamp, dl_eff;
  logic [1:0]  pos_eff;
  logic [16:0] lim;
  logic [19:0] div_q;
  logic [4:0]  div_r;

  assign uw       = ucode_rom(pc_q);
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign emit     = (uw.op == UopEmitRem) || (uw.op == UopEmitQuo) ||
                    (uw.op == UopEmitLo) || (uw.op == UopEmitHi);
  assign stall    = emit && !out_free;

  assign in_i.ready           = uw.in_ready;
  assign out_o.valid          = ov_q;
  assign out_o.digit          = digit_q;
  assign out_o.last_of_item   = lit_q;
  assign out_o.last_of_vector = lvec_q;

  assign pready = 1'b1;
  assign prdata = {24'b0, count_q};

  assign lim      = 17'(MaxDigits);
  assign dl_clamp = ({9'b0, count_q} > lim) ? lim[7:0] : count_q;
  assign dl_eff   = start_q ? dl_clamp : dl_q;
  assign pos_eff  = start_q ? 2'd0 : pos_q;

  d31_div u_div (
    .clk_i (clk_i),
    .en_i  (uw.op == UopMul),
    .w_i   (w_q),
    .q_o   (div_q),
    .r_o   (div_r)
  );

  always_comb begin
    pc_d    = uw.next;
    dl_d    = dl_q;
    store_d = store_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    w_d     = w_q;
    ov_d    = ov_q && !out_o.ready;
    digit_d = digit_q;
    lit_d   = lit_q;
    lvec_d  = lvec_q;

    case (uw.cond)
      CondWaitIn:    pc_d = accept ? uw.next : uw.alt;
      CondLoop:      pc_d = (cnt_q == 2'd3) ? uw.next : uw.alt;
      CondLastDigit: pc_d = (dl_q == 8'd1) ? uw.alt : uw.next;
      CondDispatch: begin
        if (dl_eff == 8'd0) begin
          pc_d = StFetch;
        end else if (dl_eff > 8'd4) begin
          pc_d = (pos_eff == 2'd2) ? StMul : StFetch;
        end else begin
          pc_d = StNibLo;
        end
      end
      default: pc_d = uw.next;
    endcase

    case (uw.op)
      UopLoad: begin
        if (start_q) begin
          dl_d    = dl_clamp;
          store_d = '0;
          pos_d   = '0;
        end
        if (dl_eff > 8'd4) begin
          if (pos_eff == 2'd0) begin
            store_d[7:0] = byte_q;
            pos_d        = 2'd1;
          end else if (pos_eff == 2'd1) begin
            store_d[15:8] = byte_q;
            pos_d         = 2'd2;
          end else begin
            w_d   = {byte_q, store_q};
            cnt_d = '0;
          end
        end
      end
      UopEmitRem: begin
        digit_d = div_r;
        lit_d   = 1'b0;
        w_d     = {4'b0, div_q};
        cnt_d   = cnt_q + 2'd1;
      end
      UopEmitQuo: begin
        digit_d = w_q[4:0];
        lit_d   = 1'b1;
        store_d = '0;
        pos_d   = '0;
      end
      UopEmitLo: begin
        digit_d = {1'b0, byte_q[3:0]};
        lit_d   = (dl_q == 8'd1);
      end
      UopEmitHi: begin
        digit_d = {1'b0, byte_q[7:4]};
        lit_d   = 1'b1;
      end
      default: ;
    endcase

    if (emit) begin
      ov_d   = 1'b1;
      lvec_d = (dl_q == 8'd1);
      dl_d   = dl_q - 8'd1;
    end

    if (stall) begin
      pc_d    = pc_q;
      dl_d    = dl_q;
      store_d = store_q;
      pos_d   = pos_q;
      cnt_d   = cnt_q;
      w_d     = w_q;
      ov_d    = ov_q;
      digit_d = digit_q;
      lit_d   = lit_q;
      lvec_d  = lvec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= StFetch;
      count_q <= '0;
      dl_q    <= '0;
      store_q <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      dl_q    <= dl_d;
      store_q <= store_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (psel && penable && pwrite && pready && paddr == DigitCountAddr) begin
        count_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= in_i.digest_byte;
      start_q <= in_i.start_req;
    end
    w_q     <= w_d;
    digit_q <= digit_d;
    lit_q   <= lit_d;
    lvec_q  <= lvec_d;
  end

  `ASSERT_AT(a_dl_no_grow, clk_i, rst_ni, (pc_q != StLoad) |=> (dl_q <= $past(dl_q)), "digit count grew outside load")
  `ASSERT_NEVER(a_pos_range, clk_i, rst_ni, pos_q == 2'd3, "group position out of range")
  `ASSERT_AT(a_digit_range, clk_i, rst_ni, ov_q |-> (digit_q <= 5'd30), "digit not below radix")
  `ASSERT_AT(a_quo_after_loop, clk_i, rst_ni, (pc_q == StQuo) |-> (cnt_q == 2'd0), "quotient step before four remainders")

endmodule

### dv/d31_checker.sv
`timescale 1ns / 1ps

module d31_checker
  import d31_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  d31_in_if           in_ch,
  d31_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatches_o,
  output int unsigned digits_owed_o
);

  typedef struct packed {
    logic [4:0] digit;
    logic       item_end;
    logic       vec_end;
  } digit_t;

  digit_t     digit_fifo[$];
  logic [7:0] count_reg;
  logic [7:0] left_q;
  logic [15:0] store_q;
  logic [1:0] pos_q;

  task automatic emit(input logic [4:0] v, input logic item_end);
    left_q = left_q - 8'd1;
    digit_fifo.push_back('{digit: v, item_end: item_end, vec_end: (left_q == 8'd0)});
  endtask

  task automatic expand_byte(input logic [7:0] b, input logic first);
    logic [23:0] w;
    if (first) begin
      left_q  = (count_reg > MaxDigits) ? 8'(MaxDigits) : count_reg;
      store_q = '0;
      pos_q   = '0;
    end
    if (left_q == 8'd0) return;
    if (left_q > 8'd4) begin
      case (pos_q)
        2'd0: begin
          store_q[7:0] = b;
          pos_q = 2'd1;
        end
        2'd1: begin
          store_q[15:8] = b;
          pos_q = 2'd2;
        end
        default: begin
          w = {b, store_q};
          repeat (4) begin
            emit(5'(w % Radix), 1'b0);
            w = 24'(w / Radix);
          end
          emit(w[4:0], 1'b1);
          store_q = '0;
          pos_q   = '0;
        end
      endcase
    end else if (left_q >= 8'd2) begin
      emit({1'b0, b[3:0]}, 1'b0);
      emit({1'b0, b[7:4]}, 1'b1);
    end else begin
      emit({1'b0, b[3:0]}, 1'b1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digit_t got;
    digit_t want;
    if (!rst_ni) begin
      count_reg    = '0;
      left_q       = '0;
      store_q      = '0;
      pos_q        = '0;
      mismatches_o = 0;
      digit_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == DigitCountAddr) begin
        count_reg = pwdata[7:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        expand_byte(in_ch.digest_byte, in_ch.start_req);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{digit: out_ch.digit, item_end: out_ch.last_of_item,
                vec_end: out_ch.last_of_vector};
        if (digit_fifo.size() == 0) begin
          mismatches_o++;
          $display("%0t: digit %0d item_end %b vec_end %b with none expected",
                   $time, got.digit, got.item_end, got.vec_end);
        end else begin
          want = digit_fifo.pop_front();
          if (got.digit !== want.digit || got.item_end !== want.item_end ||
              got.vec_end !== want.vec_end) begin
            mismatches_o++;
            $display("%0t: expected digit %0d item_end %b vec_end %b, got %0d %b %b",
                     $time, want.digit, want.item_end, want.vec_end,
                     got.digit, got.item_end, got.vec_end);
          end
        end
      end
    end
    digits_owed_o = digit_fifo.size();
  end

endmodule

### dv/tb_digest_to_base31_digits.sv
`timescale 1ns / 1ps

module tb_digest_to_base31_digits
  import d31_pkg::*;
;

  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned SettleCycles   = 24;
  localparam int unsigned TargetBytes    = 300;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatches;
  int unsigned digits_owed;
  bit          hold_req;
  int unsigned burst_left;

  d31_in_if  in_ch();
  d31_out_if out_ch();

  digest_to_base31_digits dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  d31_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .digits_owed_o (digits_owed)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_count(input logic [7:0] n);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DigitCountAddr;
    pwdata  <= {24'd0, n};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one request; the sender idles between bursts of random length
  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.digest_byte <= b;
    in_ch.start_req   <= first;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 10);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (digits_owed == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_digest(input logic [7:0] n, output int unsigned used);
    int unsigned left;
    int unsigned need;
    int unsigned total;
    left = n;
    need = 0;
    while (left > 4) begin
      need += 3;
      left -= 5;
    end
    need += (left + 1) / 2;
    if (need == 0) need = 1;
    case ($urandom_range(0, 9))
      0: total = need + $urandom_range(1, 3);  // trailing bytes are ignored
      1: total = (need > 1) ? $urandom_range(1, need - 1) : need;  // cut short by next start
      default: total = need;
    endcase
    for (int unsigned i = 0; i < total; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 0);
    end
    used = (total < need) ? total : need;
  endtask

  initial begin
    int unsigned mode;
    int unsigned tick;
    bit          held;
    out_ch.ready = 1'b0;
    mode = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        if (tick % 50 == 0) mode = $urandom_range(0, 3);
        tick++;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned used;
    int unsigned phase;
    int unsigned digests;
    logic [7:0]  cnt;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.digest_byte = '0;
    in_ch.start_req   = 1'b0;
    hold_req          = 1'b0;
    burst_left        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero length, then a byte after the vector is done
    write_count(8'd0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    drain();

    // full-scale group, two nibble bytes, one ignored byte
    write_count(8'd9);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h77, 1'b0);
    drain();

    // partial group dropped by a new start, zero group, single nibble
    write_count(8'd6);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h9E, 1'b0);
    drain();

    write_count(8'd1);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b1);
    drain();

    write_count(8'd4);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b0);
    drain();

    sent  = 0;
    phase = 0;
    while (sent < TargetBytes) begin
      if (phase == 0) begin
        cnt = 8'd255;
      end else begin
        case ($urandom_range(0, 9))
          0: cnt = 8'd255;
          1: cnt = 8'($urandom_range(0, 255));
          2: cnt = 8'($urandom_range(0, 4));
          default: cnt = 8'($urandom_range(1, 16));
        endcase
      end
      write_count(cnt);
      if (phase == 0) hold_req = 1'b1;
      digests = (cnt > 16) ? 1 : $urandom_range(1, 5);
      repeat (digests) begin
        send_digest(cnt, used);
        sent += used;
      end
      drain();
      phase++;
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
